// ===== rtl/pulse_width_line_receiver_assert.svh =====
// Assertion macros for the pulse-width line receiver checker.
// Pulled in by any file that asserts; no other dependencies.
`ifndef PULSE_WIDTH_LINE_RECEIVER_ASSERT_SVH
`define PULSE_WIDTH_LINE_RECEIVER_ASSERT_SVH

// Checked only outside reset.
`define PWLR_ASSERT_RUN(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PWLR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pwlr_pkg.sv =====
// Shared types and constants for the pulse-width line receiver.
// No dependencies; used by the top level and its checker.
package pwlr_pkg;

	localparam int THR_W      = 12;
	localparam int SAMPLE_W   = 12;
	localparam int BYTE_W     = 8;
	localparam int WINDOW_LEN = 5;
	localparam int FILL_W     = 3;	// holds 0..WINDOW_LEN
	localparam int BIT_W      = 4;	// holds 0..BYTE_W
	localparam int MISS_W     = 2;

	localparam logic [THR_W-1:0]  HIGH_THR_RST = 12'd3500;
	localparam logic [THR_W-1:0]  LOW_THR_RST  = 12'd1500;
	localparam logic [BYTE_W-1:0] ERROR_BYTE   = 8'hFF;
	localparam logic [BIT_W-1:0]  BYTE_DONE    = 4'd8;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 1'b1;

	typedef enum logic [1:0] {
		CLS_IDLE = 2'd0,
		CLS_LOW  = 2'd1,
		CLS_HIGH = 2'd2
	} cls_t;

	// entry 0 is the oldest sample
	typedef cls_t win_t [WINDOW_LEN];

	localparam win_t ZERO_SHAPE_A = '{CLS_LOW, CLS_LOW, CLS_LOW, CLS_HIGH, CLS_HIGH};
	localparam win_t ZERO_SHAPE_B = '{CLS_LOW, CLS_LOW, CLS_HIGH, CLS_HIGH, CLS_HIGH};
	localparam win_t ONE_SHAPE_A  = '{CLS_HIGH, CLS_HIGH, CLS_HIGH, CLS_LOW, CLS_LOW};
	localparam win_t ONE_SHAPE_B  = '{CLS_HIGH, CLS_HIGH, CLS_LOW, CLS_LOW, CLS_LOW};
	localparam win_t IDLE_SHAPE   = '{CLS_IDLE, CLS_IDLE, CLS_IDLE, CLS_IDLE, CLS_IDLE};

endpackage

// ===== rtl/pulse_width_line_receiver.sv =====
// Pulse-width line receiver: sample classing, shape decode and byte assembly.
// Depends on pwlr_pkg.
//
// Usage
//  - Input channel: in_valid / in_stall carry one converter sample
//    (adc_sample) per request. A request is taken at a rising edge with
//    in_valid high and in_stall low.
//  - Output channel: out_valid / out_stall carry one received byte
//    (rx_byte) and its frame_error flag. frame_error high means the frame
//    ended in error and rx_byte reads 255.
//  - Configuration: cfg_we writes cfg_data into high_threshold
//    (cfg_index 0) or low_threshold (cfg_index 1); write only while idle.
//  - Path: from an accepted sample to the byte it completes, the input
//    register, then decode into the result register.
//  - Throughput: one sample per cycle while the output is not stalled;
//    the whole decode step sits between the input and result registers.
//  - Most samples give no result; one byte comes out after eight bit slots.
//  - When the receiver stalls a pending byte, the sample in the input
//    register waits and in_stall goes high; no request is dropped.
//  - Reset (arst_n low) clears mode, counters and both pipeline valids and
//    restores the thresholds to 3500 and 1500. The sample window needs no
//    clearing: every entry is written before the decode reads it.
module pulse_width_line_receiver #(
	parameter int PREAMBLE_PULSES = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [pwlr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pwlr_pkg::THR_W-1:0]           cfg_data,
	// sample channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pwlr_pkg::SAMPLE_W-1:0]        adc_sample,
	// byte channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pwlr_pkg::BYTE_W-1:0]          rx_byte,
	output logic                                 frame_error
);

	localparam int PC_W = $clog2(PREAMBLE_PULSES + 2);	// counts to PREAMBLE_PULSES+1
	localparam logic [PC_W-1:0] PRE_DONE = PC_W'(PREAMBLE_PULSES);

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_SYNC  = 2'd1,
		MODE_DATA  = 2'd2,
		MODE_ERROR = 2'd3
	} mode_t;

	// configuration
	logic [pwlr_pkg::THR_W-1:0]    high_thr_q, low_thr_q;

	// input register
	logic                          valid_s1;
	logic [pwlr_pkg::SAMPLE_W-1:0] sample_s1;

	// receiver state
	pwlr_pkg::win_t                win_q;
	logic [pwlr_pkg::FILL_W-1:0]   fill_q, fill_d;
	mode_t                         mode_q, mode_d;
	logic [PC_W-1:0]               pc_q, pc_d;
	logic [pwlr_pkg::MISS_W-1:0]   miss_q, miss_d;
	logic [pwlr_pkg::BIT_W-1:0]    bitpos_q, bitpos_d;
	logic [pwlr_pkg::BYTE_W-1:0]   shift_q, shift_d;

	// result register
	logic                          out_valid_q;
	logic [pwlr_pkg::BYTE_W-1:0]   rx_byte_q;
	logic                          frame_error_q;

	// decode outputs
	logic                          adv;
	logic                          step;
	pwlr_pkg::cls_t                cls;
	logic                          win_wr, win_slide;
	logic                          emit, emit_err;
	logic [pwlr_pkg::BYTE_W-1:0]   emit_byte;
	logic                          is_zero, is_one, is_idle, err;

	// result slot is free or being emptied this cycle
	assign adv      = !out_valid_q || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	assign out_valid   = out_valid_q;
	assign rx_byte     = rx_byte_q;
	assign frame_error = frame_error_q;

	assign is_zero = (win_q == pwlr_pkg::ZERO_SHAPE_A) || (win_q == pwlr_pkg::ZERO_SHAPE_B);
	assign is_one  = (win_q == pwlr_pkg::ONE_SHAPE_A)  || (win_q == pwlr_pkg::ONE_SHAPE_B);
	assign is_idle = (win_q == pwlr_pkg::IDLE_SHAPE);

	// sample classing; the high test wins when thresholds overlap
	always_comb begin
		if (sample_s1 > high_thr_q) begin
			cls = pwlr_pkg::CLS_HIGH;
		end else if (sample_s1 < low_thr_q) begin
			cls = pwlr_pkg::CLS_LOW;
		end else begin
			cls = pwlr_pkg::CLS_IDLE;
		end
	end

	// one decode step per accepted sample
	always_comb begin
		fill_d    = fill_q;
		mode_d    = mode_q;
		pc_d      = pc_q;
		miss_d    = miss_q;
		bitpos_d  = bitpos_q;
		shift_d   = shift_q;
		win_wr    = 1'b0;
		win_slide = 1'b0;
		emit      = 1'b0;
		emit_err  = 1'b0;
		emit_byte = shift_q;
		err       = 1'b0;
		if (step) begin
			if (fill_q < pwlr_pkg::FILL_W'(pwlr_pkg::WINDOW_LEN)) begin
				// filling the window
				win_wr = 1'b1;
				fill_d = fill_q + 1'b1;
				if (cls == pwlr_pkg::CLS_HIGH && mode_q == MODE_IDLE) begin
					pc_d   = '0;
					mode_d = MODE_SYNC;
				end
			end else begin
				// decision tick; preamble completion first
				if (pc_q == PRE_DONE && mode_q != MODE_ERROR) begin
					mode_d   = MODE_DATA;
					bitpos_d = '0;
					shift_d  = '0;
					pc_d     = pc_q + 1'b1;
				end
				err = (mode_d == MODE_ERROR);
				priority if (!err && is_zero) begin
					if (mode_d == MODE_SYNC) begin
						mode_d = MODE_ERROR;	// zero before data: window kept as is
					end else begin
						bitpos_d = bitpos_d + 1'b1;
						fill_d   = '0;
						miss_d   = '0;
					end
				end else if (!err && is_one) begin
					if (pc_d < PRE_DONE) begin
						pc_d = pc_d + 1'b1;
					end else begin
						if (bitpos_d < pwlr_pkg::BYTE_DONE) begin
							shift_d[bitpos_d[2:0]] = 1'b1;
						end
						bitpos_d = bitpos_d + 1'b1;
					end
					fill_d = '0;
					miss_d = '0;
				end else if (!err && is_idle) begin
					if (mode_d == MODE_DATA || mode_d == MODE_SYNC) begin
						mode_d = MODE_ERROR;
					end
					fill_d = '0;
					miss_d = '0;
				end else begin
					// no shape: slide by one; third miss forces error
					if (miss_q > 2'd1) begin
						mode_d = MODE_ERROR;
					end
					if (mode_d == MODE_ERROR) begin
						bitpos_d = bitpos_d + 1'b1;
					end else begin
						miss_d = miss_q + 1'b1;
					end
					win_slide = 1'b1;
					fill_d    = pwlr_pkg::FILL_W'(pwlr_pkg::WINDOW_LEN - 1);
				end
				// end of byte
				if (bitpos_d >= pwlr_pkg::BYTE_DONE) begin
					emit      = 1'b1;
					emit_err  = (mode_d == MODE_ERROR);
					emit_byte = emit_err ? pwlr_pkg::ERROR_BYTE : shift_d;
					miss_d    = '0;
					bitpos_d  = '0;
					shift_d   = '0;
					pc_d      = '0;
					mode_d    = MODE_IDLE;
				end
			end
		end
	end

	// control state, thresholds, input register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q    <= pwlr_pkg::HIGH_THR_RST;
			low_thr_q     <= pwlr_pkg::LOW_THR_RST;
			valid_s1      <= 1'b0;
			sample_s1     <= '0;
			fill_q        <= '0;
			mode_q        <= MODE_IDLE;
			pc_q          <= '0;
			miss_q        <= '0;
			bitpos_q      <= '0;
			shift_q       <= '0;
			out_valid_q   <= 1'b0;
			rx_byte_q     <= '0;
			frame_error_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pwlr_pkg::REG_HIGH_THR: high_thr_q <= cfg_data;
					pwlr_pkg::REG_LOW_THR:  low_thr_q  <= cfg_data;
					default: ;
				endcase
			end
			if (!in_stall) begin
				valid_s1  <= in_valid;
				sample_s1 <= adc_sample;
			end
			fill_q   <= fill_d;
			mode_q   <= mode_d;
			pc_q     <= pc_d;
			miss_q   <= miss_d;
			bitpos_q <= bitpos_d;
			shift_q  <= shift_d;
			if (adv) begin
				out_valid_q   <= emit;
				rx_byte_q     <= emit_byte;
				frame_error_q <= emit_err;
			end
		end
	end

	// sample window: written before read, so no reset
	always_ff @(posedge clk) begin
		if (win_wr) begin
			win_q[fill_q] <= cls;
		end else if (win_slide) begin
			for (int i = 0; i < pwlr_pkg::WINDOW_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end
	end

endmodule

// ===== rtl/pwlr_checker.sv =====
// Port-level checker for the pulse-width line receiver, with its bind.
// Depends on pwlr_pkg and pulse_width_line_receiver_assert.svh.
`include "pulse_width_line_receiver_assert.svh"

module pwlr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [pwlr_pkg::BYTE_W-1:0]    rx_byte,
	input logic                           frame_error
);

	// error frames always read as the error byte
	`PWLR_ASSERT_ALWAYS(a_err_byte, out_valid && frame_error |-> rx_byte == pwlr_pkg::ERROR_BYTE, "error frame without error byte")

	// input only backs up behind a stalled result
	`PWLR_ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled while output free")

	// a fresh result follows a request taken through the input register
	`PWLR_ASSERT_RUN(a_latency, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without matching request")

	// stalled result holds
	`PWLR_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(rx_byte) && $stable(frame_error), "stalled result changed")

endmodule

bind pulse_width_line_receiver pwlr_checker u_pwlr_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for pulse_width_line_receiver: drives converter samples and threshold
// writes, predicts every received byte with a cycle-free decoder model, checks the byte channel.
// Depends on pwlr_pkg and the receiver RTL only.
`timescale 1ns / 100ps

module tb_top;

	localparam int PREAMBLE     = 3;
	localparam int MAX_SAMPLE   = (1 << pwlr_pkg::SAMPLE_W) - 1;
	localparam int DRAIN_CYCLES = 6;	// pipeline is two deep; a little slack on top
	localparam int RUN_LIMIT_NS = 5_000_000;
	localparam int ITEMS        = 1300;

	typedef logic [pwlr_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic [pwlr_pkg::THR_W-1:0]    thr_t;
	typedef logic [pwlr_pkg::BYTE_W-1:0]   byte_t;
	typedef logic [pwlr_pkg::FILL_W-1:0]   fill_t;

	// opening run: one-shape in idle (enters sync), zero-shape while in sync (error),
	// then the error frame drains two requests per bit slot until the error byte appears
	localparam sample_t OPENING_RUN [27] = '{
		12'd4095, 12'd4095, 12'd3501, 12'd0, 12'd1499, 12'd2048,
		12'd0, 12'd1, 12'd1499, 12'd3501, 12'd4095, 12'd3500,
		12'd1500, 12'd3500, 12'd1500, 12'd3500, 12'd2730, 12'd1365, 12'd1500,
		12'd3500, 12'd4095, 12'd0, 12'd1500, 12'd3500, 12'd2048, 12'd2047, 12'd1500
	};

	typedef enum logic [1:0] {RX_IDLE, RX_SYNC, RX_DATA, RX_ERROR} rx_mode_t;

	typedef struct packed {
		byte_t value;
		logic  err;
	} rx_frame_t;

	// window patterns, oldest sample in the top bits
	localparam logic [9:0] ZERO_A = {pwlr_pkg::CLS_LOW, pwlr_pkg::CLS_LOW, pwlr_pkg::CLS_LOW,
		pwlr_pkg::CLS_HIGH, pwlr_pkg::CLS_HIGH};
	localparam logic [9:0] ZERO_B = {pwlr_pkg::CLS_LOW, pwlr_pkg::CLS_LOW, pwlr_pkg::CLS_HIGH,
		pwlr_pkg::CLS_HIGH, pwlr_pkg::CLS_HIGH};
	localparam logic [9:0] ONE_A  = {pwlr_pkg::CLS_HIGH, pwlr_pkg::CLS_HIGH, pwlr_pkg::CLS_HIGH,
		pwlr_pkg::CLS_LOW, pwlr_pkg::CLS_LOW};
	localparam logic [9:0] ONE_B  = {pwlr_pkg::CLS_HIGH, pwlr_pkg::CLS_HIGH, pwlr_pkg::CLS_LOW,
		pwlr_pkg::CLS_LOW, pwlr_pkg::CLS_LOW};
	localparam logic [9:0] QUIET  = {pwlr_pkg::CLS_IDLE, pwlr_pkg::CLS_IDLE, pwlr_pkg::CLS_IDLE,
		pwlr_pkg::CLS_IDLE, pwlr_pkg::CLS_IDLE};

	// Decoder model plus the queue of bytes it says must come out.
	class frame_decoder;
		thr_t                            high_thr = pwlr_pkg::HIGH_THR_RST;
		thr_t                            low_thr  = pwlr_pkg::LOW_THR_RST;
		pwlr_pkg::cls_t                  win [pwlr_pkg::WINDOW_LEN];
		fill_t                           fill     = '0;
		rx_mode_t                        mode     = RX_IDLE;
		logic [2:0]                      pre_cnt  = '0;
		logic [pwlr_pkg::MISS_W-1:0]     miss     = '0;
		logic [pwlr_pkg::BIT_W-1:0]      slot     = '0;
		byte_t                           shreg    = '0;
		rx_frame_t                       frames_due [$];
		int unsigned                     fail_cnt;

		function bit decision_due();
			return fill == pwlr_pkg::WINDOW_LEN;
		endfunction

		function void note_sample(sample_t s);
			pwlr_pkg::cls_t c;
			logic [9:0]     w;
			logic           in_err;
			rx_frame_t      f;
			int             i;
			if (fill < pwlr_pkg::WINDOW_LEN) begin
				// high test first, so overlapping thresholds class as high
				if (s > high_thr) begin
					c = pwlr_pkg::CLS_HIGH;
					if (mode == RX_IDLE) begin
						pre_cnt = '0;
						mode = RX_SYNC;
					end
				end else if (s < low_thr) begin
					c = pwlr_pkg::CLS_LOW;
				end else begin
					c = pwlr_pkg::CLS_IDLE;
				end
				win[fill] = c;
				fill++;
				return;
			end
			// decision request: sample value plays no part
			if (pre_cnt == PREAMBLE && mode != RX_ERROR) begin
				mode = RX_DATA;
				slot = '0;
				shreg = '0;
				pre_cnt++;
			end
			in_err = (mode == RX_ERROR);
			w = {win[0], win[1], win[2], win[3], win[4]};
			if (!in_err && (w == ZERO_A || w == ZERO_B)) begin
				if (mode == RX_SYNC) begin
					mode = RX_ERROR;	// window stays full
				end else begin
					slot++;
					fill = '0;
					miss = '0;
				end
			end else if (!in_err && (w == ONE_A || w == ONE_B)) begin
				if (pre_cnt < PREAMBLE) begin
					pre_cnt++;
				end else begin
					if (slot < pwlr_pkg::BYTE_DONE)
						shreg[slot[2:0]] = 1'b1;
					slot++;
				end
				fill = '0;
				miss = '0;
			end else if (!in_err && w == QUIET) begin
				if (mode == RX_DATA || mode == RX_SYNC)
					mode = RX_ERROR;
				fill = '0;
				miss = '0;
			end else begin
				if (miss > 1)
					mode = RX_ERROR;
				if (mode == RX_ERROR)
					slot++;
				else
					miss++;
				for (i = 0; i < pwlr_pkg::WINDOW_LEN - 1; i++)
					win[i] = win[i + 1];
				fill = fill_t'(pwlr_pkg::WINDOW_LEN - 1);
			end
			if (slot >= pwlr_pkg::BYTE_DONE) begin
				f.err = (mode == RX_ERROR);
				f.value = f.err ? pwlr_pkg::ERROR_BYTE : shreg;
				frames_due.push_back(f);
				miss = '0;
				slot = '0;
				shreg = '0;
				pre_cnt = '0;
				mode = RX_IDLE;
			end
		endfunction

		function void check_byte(byte_t b, logic e);
			rx_frame_t x;
			if (frames_due.size() == 0) begin
				$display("%0t: byte with none expected: rx_byte %0d frame_error %0b",
					$time, b, e);
				fail_cnt++;
				return;
			end
			x = frames_due.pop_front();
			if (b !== x.value) begin
				$display("%0t: rx_byte expected %0d actual %0d", $time, x.value, b);
				fail_cnt++;
			end
			if (e !== x.err) begin
				$display("%0t: frame_error expected %0b actual %0b", $time, x.err, e);
				fail_cnt++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n     = 1'b0;
	logic                           cfg_we     = 1'b0;
	logic [pwlr_pkg::CFG_IDX_W-1:0] cfg_index  = pwlr_pkg::REG_HIGH_THR;
	thr_t                           cfg_data   = '0;
	logic                           in_valid   = 1'b0;
	logic                           in_stall;
	sample_t                        adc_sample = '0;
	logic                           out_valid;
	logic                           out_stall  = 1'b0;
	byte_t                          rx_byte;
	logic                           frame_error;

	frame_decoder book = new();
	int unsigned  burst_left;
	int unsigned  samples_taken;

	pulse_width_line_receiver #(.PREAMBLE_PULSES(PREAMBLE)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rx_byte    (rx_byte),
		.frame_error(frame_error)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Byte channel: sampled at the edge, so values are the ones present before it.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_byte(rx_byte, frame_error);
	end

	// Receiver back-pressure. Segments of free flow, sparse, dense and toggling stall,
	// plus one long hold-off so the byte register fills and the sample side backs up.
	initial begin
		int unsigned ticks;
		int unsigned seg;
		int unsigned style;
		bit          held;
		ticks = 0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held && ticks >= 400) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				ticks += 300;
				held = 1'b1;
			end
			style = $urandom_range(0, 3);
			seg = $urandom_range(10, 80);
			repeat (seg) begin
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					2: out_stall <= ~out_stall;
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
				ticks++;
			end
		end
	end

	// One sample request; the decoder model sees it at the edge it is taken.
	// Bursts of random length, then a random gap with valid low.
	task automatic push_sample(input sample_t s);
		int unsigned gap;
		adc_sample <= s;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		book.note_sample(s);
		samples_taken++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
				: $urandom_range(0, 24);
		end
	endtask

	// A sample of the wanted class under the current thresholds; edges favoured.
	// Falls back to any value when the thresholds leave no room for that class.
	function automatic sample_t sample_for(pwlr_pkg::cls_t c);
		int lo_edge;
		int hi_edge;
		int hi;
		int lo;
		bit ok;
		hi = int'(book.high_thr);
		lo = int'(book.low_thr);
		ok = 1'b0;
		case (c)
			pwlr_pkg::CLS_HIGH: begin
				if (hi < MAX_SAMPLE) begin
					lo_edge = hi + 1;
					hi_edge = MAX_SAMPLE;
					ok = 1'b1;
				end
			end
			pwlr_pkg::CLS_LOW: begin
				if (lo > 0) begin
					lo_edge = 0;
					hi_edge = (hi < lo - 1) ? hi : lo - 1;
					ok = 1'b1;
				end
			end
			default: begin
				if (lo <= hi) begin
					lo_edge = lo;
					hi_edge = hi;
					ok = 1'b1;
				end
			end
		endcase
		if (!ok)
			return sample_t'($urandom_range(0, MAX_SAMPLE));
		case ($urandom_range(0, 7))
			0: return sample_t'(lo_edge);
			1: return sample_t'(hi_edge);
			default: return sample_t'($urandom_range(hi_edge, lo_edge));
		endcase
	endfunction

	// Fill decision slots with throwaway samples so the class lands in the window.
	task automatic push_class(input pwlr_pkg::cls_t c);
		while (book.decision_due())
			push_sample(sample_t'($urandom_range(0, MAX_SAMPLE)));
		push_sample(sample_for(c));
	endtask

	// One five-sample pulse; noise != 0 corrupts about one class in noise.
	task automatic send_shape(input logic one, input int unsigned noise);
		pwlr_pkg::cls_t seq [pwlr_pkg::WINDOW_LEN];
		int             i;
		if (one) begin
			seq[0] = pwlr_pkg::CLS_HIGH;
			seq[1] = pwlr_pkg::CLS_HIGH;
			seq[2] = $urandom_range(0, 1) ? pwlr_pkg::CLS_HIGH : pwlr_pkg::CLS_LOW;
			seq[3] = pwlr_pkg::CLS_LOW;
			seq[4] = pwlr_pkg::CLS_LOW;
		end else begin
			seq[0] = pwlr_pkg::CLS_LOW;
			seq[1] = pwlr_pkg::CLS_LOW;
			seq[2] = $urandom_range(0, 1) ? pwlr_pkg::CLS_LOW : pwlr_pkg::CLS_HIGH;
			seq[3] = pwlr_pkg::CLS_HIGH;
			seq[4] = pwlr_pkg::CLS_HIGH;
		end
		for (i = 0; i < pwlr_pkg::WINDOW_LEN; i++) begin
			if (noise != 0 && $urandom_range(1, noise) == 1) begin
				push_class(pwlr_pkg::cls_t'($urandom_range(0, 2)));
				if ($urandom_range(0, 1))
					push_class(seq[i]);	// inserted rather than replaced: misaligns
			end else begin
				push_class(seq[i]);
			end
		end
	endtask

	// Preamble pulses then eight data pulses, LSB first. Now and then a short or
	// long preamble to push the preamble counter off its usual path.
	task automatic send_frame(input int unsigned noise);
		byte_t       data;
		int unsigned npre;
		int          i;
		data = byte_t'($urandom);
		npre = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : PREAMBLE;
		repeat (npre) send_shape(1'b1, noise);
		for (i = 0; i < pwlr_pkg::BYTE_W; i++)
			send_shape(data[i], noise);
	endtask

	task automatic run_segment();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: send_frame(0);
			6, 7: send_frame(12);
			8: repeat ($urandom_range(1, 15))
				push_sample(sample_t'($urandom_range(0, MAX_SAMPLE)));
			default: begin
				if ($urandom_range(0, 1))
					repeat ($urandom_range(1, 2) * pwlr_pkg::WINDOW_LEN)
						push_class(pwlr_pkg::CLS_IDLE);
				else
					send_shape(1'b0, 0);
			end
		endcase
	endtask

	// Stop offering requests and let every predicted byte out, then the pipeline settle.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (book.frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both thresholds, back to back, only once the receiver has gone quiet.
	task automatic set_thresholds(input thr_t hi, input thr_t lo);
		quiesce();
		cfg_we <= 1'b1;
		cfg_index <= pwlr_pkg::REG_HIGH_THR;
		cfg_data <= hi;
		@(posedge clk);
		book.high_thr = hi;
		cfg_index <= pwlr_pkg::REG_LOW_THR;
		cfg_data <= lo;
		@(posedge clk);
		book.low_thr = lo;
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned phase_no;
		int unsigned kind;
		int unsigned span;
		int unsigned start;
		int          i;
		thr_t        hi;
		thr_t        lo;
		burst_left = 0;
		samples_taken = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening, default thresholds written explicitly
		set_thresholds(pwlr_pkg::HIGH_THR_RST, pwlr_pkg::LOW_THR_RST);
		for (i = 0; i < 27; i++)
			push_sample(OPENING_RUN[i]);

		// random phases: overlapping thresholds first, then both extremes, then a mix
		phase_no = 0;
		while (samples_taken < ITEMS) begin
			case (phase_no)
				0: kind = 2;
				1: kind = 3;
				2: kind = 4;
				default: kind = $urandom_range(0, 5);
			endcase
			case (kind)
				0: begin
					hi = pwlr_pkg::HIGH_THR_RST;
					lo = pwlr_pkg::LOW_THR_RST;
				end
				1: begin
					lo = thr_t'($urandom_range(1, 3000));
					hi = thr_t'($urandom_range(lo, MAX_SAMPLE - 1));
				end
				2: begin
					hi = thr_t'($urandom_range(200, 2000));
					lo = thr_t'($urandom_range(hi + 1, MAX_SAMPLE));
				end
				3: begin
					// nothing classes high or low
					hi = thr_t'(MAX_SAMPLE);
					lo = '0;
				end
				4: begin
					// only zero classes low
					hi = '0;
					lo = thr_t'(MAX_SAMPLE);
				end
				default: begin
					hi = thr_t'($urandom_range(0, MAX_SAMPLE));
					lo = thr_t'($urandom_range(0, MAX_SAMPLE));
				end
			endcase
			set_thresholds(hi, lo);
			span = (kind == 3) ? 40 : $urandom_range(150, 300);
			start = samples_taken;
			while (samples_taken - start < span && samples_taken < ITEMS)
				run_segment();
			phase_no++;
		end

		quiesce();
		if (book.fail_cnt == 0 && book.frames_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("Verification failed");
		$finish;
	end

endmodule
